@@ hdl/sac_pkg.sv @@
// Shared constants, request kind codes and controller/datapath interface types.
package sac_pkg;

  // Defaults for the top-level parameters.
  localparam int MAX_REQUESTS = 16;
  localparam int SIZE_BITS    = 16;

  // Fixed widths of the payload ports.
  localparam int KIND_W  = 2;
  localparam int FIELD_W = 16;

  // Percentages are taken out of this base.
  localparam int PCT_BASE = 100;

  // Floor division by PCT_BASE for any dividend below 2**32: multiply by the
  // reciprocal scaled by 2**PCT_SHIFT and rounded up, then drop PCT_SHIFT bits.
  localparam int          PCT_RECIP_W = 32;
  localparam logic [31:0] PCT_RECIP   = 32'h51EB851F;
  localparam int          PCT_SHIFT   = 37;

  // Request kind codes as stored; a set high bit always means wildcard.
  localparam logic [KIND_W-1:0] KIND_FIXED = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PCT   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_WILD  = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic store;      // take the offered transaction into the set
    logic clear_set;  // drop the set bookkeeping for the next set
    logic start_pct;  // set up the percentage pass
    logic start_wild; // set up the wildcard pass
    logic start_out;  // set up the result pass
    logic rd_en;      // read the stored request at the current index
    logic idx_inc;    // advance the index
    logic pct_div;    // start amount * rest / base
    logic wild_div;   // start remaining / wildcards left
    logic pct_done;   // commit a percentage grant
    logic wild_done;  // commit a wildcard share
    logic wild_last;  // give the rest to the final wildcard
    logic err_sel;    // present the error result
  } sac_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic              at_end;
    logic              out_last;
    logic              fixed_over;
    logic              alloc_over;
    logic              wild_multi;
    logic              div_done;
    logic [KIND_W-1:0] rd_kind;
  } sac_status_t;

endpackage

@@ hdl/sac_div.sv @@
// Bit-serial restoring divider, one quotient bit per cycle.
module sac_div #(
  parameter int DW = 32,
  parameter int VW = 7
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  output logic          done_o,
  output logic [DW-1:0] quot_o
);

  localparam int CW = $clog2(DW);

  logic          busy_q, busy_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [DW-1:0] quo_q, quo_d;
  logic [VW-1:0] rem_q, rem_d;
  logic [VW-1:0] dsr_q, dsr_d;
  logic [VW:0]   trial;
  logic          fits;

  // One shift, compare and subtract step.
  assign trial = {rem_q, quo_q[DW-1]};
  assign fits  = trial >= {1'b0, dsr_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = fits ? VW'(trial - {1'b0, dsr_q}) : VW'(trial);
      quo_d = {quo_q[DW-2:0], fits};
      cnt_d = cnt_q + CW'(1);
      if (cnt_q == CW'(DW - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign done_o = !busy_q;
  assign quot_o = quo_q;

endmodule

@@ hdl/sac_datapath.sv @@
// Request store, set bookkeeping and grant arithmetic.
module sac_datapath #(
  parameter int MAX_REQUESTS = sac_pkg::MAX_REQUESTS,
  parameter int SIZE_BITS    = sac_pkg::SIZE_BITS
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  sac_pkg::sac_cmd_t          cmd_i,
  output sac_pkg::sac_status_t       status_o,
  input  logic [sac_pkg::KIND_W-1:0] kind_i,
  input  logic [sac_pkg::FIELD_W-1:0] amount_i,
  input  logic [sac_pkg::FIELD_W-1:0] total_i,
  output logic [sac_pkg::FIELD_W-1:0] allocation_o
);

  localparam int S    = SIZE_BITS;
  localparam int KW   = sac_pkg::KIND_W;
  localparam int FW   = sac_pkg::FIELD_W;
  localparam int CntW = $clog2(MAX_REQUESTS + 1);
  localparam int AW   = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
  localparam int FsW  = S + CntW;
  localparam int EW   = (S < FW) ? S : FW;
  localparam int PW   = 2 * EW;
  localparam int RW   = sac_pkg::PCT_RECIP_W;
  localparam int MW   = 2 * RW;
  localparam int QW   = MW - sac_pkg::PCT_SHIFT;
  localparam int AlW  = 2 * S + CntW + 1;
  localparam int VW   = CntW;
  localparam int WW   = KW + S;

  logic [WW-1:0]   mem [MAX_REQUESTS];
  logic [WW-1:0]   rd_q;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] wild_q, wild_d;
  logic [CntW-1:0] wleft_q, wleft_d;
  logic [CntW-1:0] idx_q, idx_d;
  logic [S-1:0]    total_q, total_d;
  logic [FsW-1:0]  fixed_q, fixed_d;
  logic [S-1:0]    rest_q, rest_d;
  logic [AlW-1:0]  alloc_q, alloc_d;
  logic [S-1:0]    remain_q, remain_d;
  logic [PW-1:0]   prod_q, prod_d;
  logic [MW-1:0]   scaled_q, scaled_d;
  logic            pct_busy_q;

  logic [KW-1:0]   kind_n;
  logic [S-1:0]    amt_s;
  logic [S-1:0]    tot_s;
  logic            has_room;
  logic [KW-1:0]   rd_kind;
  logic [S-1:0]    rd_amt;
  logic            we;
  logic [AW-1:0]   waddr;
  logic [WW-1:0]   wdata;
  logic [QW-1:0]   pct_quot;
  logic [VW-1:0]   div_divisor;
  logic            div_done;
  logic [S-1:0]    quot;

  // Incoming fields brought to the internal size; kind three counts as wildcard.
  assign kind_n   = kind_i[1] ? sac_pkg::KIND_WILD : kind_i;
  assign amt_s    = S'(amount_i);
  assign tot_s    = S'(total_i);
  assign has_room = count_q < CntW'(MAX_REQUESTS);
  assign rd_kind  = rd_q[WW-1:S];
  assign rd_amt   = rd_q[S-1:0];

  // Percentage grant: amount * rest is registered, then the reciprocal multiply.
  assign prod_d   = PW'(rd_amt[EW-1:0]) * PW'(rest_q[EW-1:0]);
  assign scaled_d = MW'(RW'(prod_q)) * MW'(sac_pkg::PCT_RECIP);
  assign pct_quot = scaled_q[MW-1:sac_pkg::PCT_SHIFT];

  always_ff @(posedge clk_i) begin
    prod_q   <= prod_d;
    scaled_q <= scaled_d;
  end

  // Serial divider for wildcard shares.
  assign div_divisor = wleft_q;

  sac_div #(
    .DW(S),
    .VW(VW)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.wild_div),
    .dividend_i(remain_q),
    .divisor_i (div_divisor),
    .done_o    (div_done),
    .quot_o    (quot)
  );

  // Single write port: loading writes at the fill position, passes write back grants.
  always_comb begin
    we    = 1'b0;
    waddr = idx_q[AW-1:0];
    wdata = {rd_kind, rd_amt};
    if (cmd_i.store && has_room) begin
      we    = 1'b1;
      waddr = count_q[AW-1:0];
      wdata = {kind_n, amt_s};
    end else if (cmd_i.pct_done) begin
      we    = 1'b1;
      wdata = {rd_kind, S'(pct_quot)};
    end else if (cmd_i.wild_done) begin
      we    = 1'b1;
      wdata = {rd_kind, quot};
    end else if (cmd_i.wild_last) begin
      we    = 1'b1;
      wdata = {rd_kind, remain_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (cmd_i.rd_en) begin
      rd_q <= mem[idx_q[AW-1:0]];
    end
  end

  // Set bookkeeping and pass registers.
  always_comb begin
    count_d  = count_q;
    wild_d   = wild_q;
    wleft_d  = wleft_q;
    idx_d    = idx_q;
    total_d  = total_q;
    fixed_d  = fixed_q;
    rest_d   = rest_q;
    alloc_d  = alloc_q;
    remain_d = remain_q;
    if (cmd_i.store && has_room) begin
      if (count_q == '0) begin
        total_d = tot_s;
      end
      if (kind_n == sac_pkg::KIND_FIXED) begin
        fixed_d = fixed_q + FsW'(amt_s);
      end else if (kind_n == sac_pkg::KIND_WILD) begin
        wild_d = wild_q + CntW'(1);
      end
      count_d = count_q + CntW'(1);
    end
    if (cmd_i.start_pct) begin
      rest_d  = total_q - fixed_q[S-1:0];
      alloc_d = AlW'(fixed_q);
      idx_d   = '0;
    end
    if (cmd_i.start_wild) begin
      remain_d = total_q - alloc_q[S-1:0];
      wleft_d  = wild_q;
      idx_d    = '0;
    end
    if (cmd_i.start_out) begin
      idx_d = '0;
    end
    if (cmd_i.pct_done) begin
      alloc_d = alloc_q + AlW'(pct_quot);
    end
    if (cmd_i.wild_done) begin
      remain_d = remain_q - quot;
      wleft_d  = wleft_q - CntW'(1);
    end
    if (cmd_i.wild_last) begin
      remain_d = '0;
    end
    if (cmd_i.idx_inc) begin
      idx_d = idx_q + CntW'(1);
    end
    if (cmd_i.clear_set) begin
      count_d = '0;
      wild_d  = '0;
      total_d = '0;
      fixed_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      wild_q     <= '0;
      wleft_q    <= '0;
      idx_q      <= '0;
      total_q    <= '0;
      fixed_q    <= '0;
      rest_q     <= '0;
      alloc_q    <= '0;
      remain_q   <= '0;
      pct_busy_q <= 1'b0;
    end else begin
      count_q    <= count_d;
      wild_q     <= wild_d;
      wleft_q    <= wleft_d;
      idx_q      <= idx_d;
      total_q    <= total_d;
      fixed_q    <= fixed_d;
      rest_q     <= rest_d;
      alloc_q    <= alloc_d;
      remain_q   <= remain_d;
      pct_busy_q <= cmd_i.pct_div;
    end
  end

  // Status back to the controller.
  assign status_o.at_end     = idx_q == count_q;
  assign status_o.out_last   = (idx_q + CntW'(1)) == count_q;
  assign status_o.fixed_over = fixed_q > FsW'(total_q);
  assign status_o.alloc_over = alloc_q > AlW'(total_q);
  assign status_o.wild_multi = wleft_q > CntW'(1);
  assign status_o.div_done   = div_done && !pct_busy_q;
  assign status_o.rd_kind    = rd_kind;

  assign allocation_o = cmd_i.err_sel ? '0 : FW'(rd_amt);

endmodule

@@ hdl/sac_ctrl.sv @@
// Sequencer for loading a set, the two grant passes and result delivery.
module sac_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 last_request_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 over_allocated_o,
  output logic                 last_result_o,
  output sac_pkg::sac_cmd_t    cmd_o,
  input  sac_pkg::sac_status_t status_i
);

  localparam logic [3:0] ST_LOAD    = 4'd0;
  localparam logic [3:0] ST_CHECK   = 4'd1;
  localparam logic [3:0] ST_P1_RD   = 4'd2;
  localparam logic [3:0] ST_P1_EVAL = 4'd3;
  localparam logic [3:0] ST_P1_DIV  = 4'd4;
  localparam logic [3:0] ST_P1_CHK  = 4'd5;
  localparam logic [3:0] ST_P2_RD   = 4'd6;
  localparam logic [3:0] ST_P2_EVAL = 4'd7;
  localparam logic [3:0] ST_P2_DIV  = 4'd8;
  localparam logic [3:0] ST_OUT_RD  = 4'd9;
  localparam logic [3:0] ST_OUT     = 4'd10;
  localparam logic [3:0] ST_ERR     = 4'd11;

  logic [3:0] state_q, state_d;

  always_comb begin
    state_d          = state_q;
    cmd_o            = '0;
    in_ready_o       = 1'b0;
    out_valid_o      = 1'b0;
    over_allocated_o = 1'b0;
    last_result_o    = 1'b0;
    unique case (state_q)
      // Collect requests until the one marked last.
      ST_LOAD: begin
        in_ready_o  = 1'b1;
        cmd_o.store = in_valid_i;
        if (in_valid_i && last_request_i) begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (status_i.fixed_over) begin
          state_d = ST_ERR;
        end else begin
          cmd_o.start_pct = 1'b1;
          state_d         = ST_P1_RD;
        end
      end
      // Percentage pass: grant each percentage request its share of the rest.
      ST_P1_RD: begin
        if (status_i.at_end) begin
          state_d = ST_P1_CHK;
        end else begin
          cmd_o.rd_en = 1'b1;
          state_d     = ST_P1_EVAL;
        end
      end
      ST_P1_EVAL: begin
        if (status_i.rd_kind == sac_pkg::KIND_PCT) begin
          cmd_o.pct_div = 1'b1;
          state_d       = ST_P1_DIV;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d       = ST_P1_RD;
        end
      end
      ST_P1_DIV: begin
        if (status_i.div_done) begin
          cmd_o.pct_done = 1'b1;
          cmd_o.idx_inc  = 1'b1;
          state_d        = ST_P1_RD;
        end
      end
      ST_P1_CHK: begin
        if (status_i.alloc_over) begin
          state_d = ST_ERR;
        end else begin
          cmd_o.start_wild = 1'b1;
          state_d          = ST_P2_RD;
        end
      end
      // Wildcard pass: even shares in load order, the final one takes the rest.
      ST_P2_RD: begin
        if (status_i.at_end) begin
          cmd_o.start_out = 1'b1;
          state_d         = ST_OUT_RD;
        end else begin
          cmd_o.rd_en = 1'b1;
          state_d     = ST_P2_EVAL;
        end
      end
      ST_P2_EVAL: begin
        if (status_i.rd_kind == sac_pkg::KIND_WILD) begin
          if (status_i.wild_multi) begin
            cmd_o.wild_div = 1'b1;
            state_d        = ST_P2_DIV;
          end else begin
            cmd_o.wild_last = 1'b1;
            cmd_o.idx_inc   = 1'b1;
            state_d         = ST_P2_RD;
          end
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d       = ST_P2_RD;
        end
      end
      ST_P2_DIV: begin
        if (status_i.div_done) begin
          cmd_o.wild_done = 1'b1;
          cmd_o.idx_inc   = 1'b1;
          state_d         = ST_P2_RD;
        end
      end
      // Deliver one grant per stored request.
      ST_OUT_RD: begin
        cmd_o.rd_en = 1'b1;
        state_d     = ST_OUT;
      end
      ST_OUT: begin
        out_valid_o   = 1'b1;
        last_result_o = status_i.out_last;
        if (out_ready_i) begin
          if (status_i.out_last) begin
            cmd_o.clear_set = 1'b1;
            state_d         = ST_LOAD;
          end else begin
            cmd_o.idx_inc = 1'b1;
            state_d       = ST_OUT_RD;
          end
        end
      end
      // Single error transaction for an overrun set.
      ST_ERR: begin
        out_valid_o      = 1'b1;
        over_allocated_o = 1'b1;
        last_result_o    = 1'b1;
        cmd_o.err_sel    = 1'b1;
        if (out_ready_i) begin
          cmd_o.clear_set = 1'b1;
          state_d         = ST_LOAD;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ hdl/share_allocator_fixed_percent_wildcard.sv @@
// Share allocator top level: splits a total among fixed, percentage and wildcard requests.
// Requests load at one transaction per cycle; the set's last request starts the split.
// The check is followed by the percentage pass and then the wildcard pass over the stored
// requests; each percentage request and each wildcard but the final one waits for its share.
// Input is not taken while a set is being split or its results are delivered.
// Reset (asynchronous, active low) empties the current set; the request store is not cleared.
module share_allocator_fixed_percent_wildcard #(
  parameter int MAX_REQUESTS = sac_pkg::MAX_REQUESTS,
  parameter int SIZE_BITS    = sac_pkg::SIZE_BITS
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [sac_pkg::KIND_W-1:0]  kind_i,
  input  logic [sac_pkg::FIELD_W-1:0] amount_i,
  input  logic [sac_pkg::FIELD_W-1:0] total_i,
  input  logic                        last_request_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [sac_pkg::FIELD_W-1:0] allocation_o,
  output logic                        over_allocated_o,
  output logic                        last_result_o
);

  sac_pkg::sac_cmd_t    cmd;
  sac_pkg::sac_status_t status;

  // Sequencer.
  sac_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .last_request_i  (last_request_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .over_allocated_o(over_allocated_o),
    .last_result_o   (last_result_o),
    .cmd_o           (cmd),
    .status_i        (status)
  );

  // Storage and arithmetic.
  sac_datapath #(
    .MAX_REQUESTS(MAX_REQUESTS),
    .SIZE_BITS   (SIZE_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .kind_i      (kind_i),
    .amount_i    (amount_i),
    .total_i     (total_i),
    .allocation_o(allocation_o)
  );

endmodule
